[rtl/core/min_heap_insert_delete_macros.svh]
// Assertion macros shared by the heap checker.
// Depends on nothing; included by files that assert.
`ifndef MIN_HEAP_INSERT_DELETE_MACROS_SVH
`define MIN_HEAP_INSERT_DELETE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/mhid_pkg.sv]
// Package for the binary min-heap: sizes, codes, payload and control types.
// Depends on nothing.
package mhid_pkg;
  localparam int HeapDepth = 16;
  localparam int ValueBits = 32;
  localparam int IdxBits = $clog2(HeapDepth);
  localparam int CntBits = $clog2(HeapDepth + 1);

  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;
  typedef logic signed [ValueBits-1:0] val_t;

  localparam logic ActInsert = 1'b0;
  localparam logic ActDelete = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic action;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic signed [31:0] min_value;
    logic heap_empty;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DEL_A,
    S_DEL_B,
    S_NODE,
    S_RD_N,
    S_RD_L,
    S_RD_R,
    S_DECIDE,
    S_SWAP_A,
    S_ROOT,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_LOAD,
    C_APPEND,
    C_SRCH_RD,
    C_SRCH_STEP,
    C_DEL_A,
    C_DEL_B,
    C_NODE_INIT,
    C_RD_N,
    C_RD_L,
    C_RD_R,
    C_SWAP_A,
    C_SWAP_B,
    C_NODE_NEXT,
    C_RD_ROOT,
    C_STATUS
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    status_t status;
  } ctl_t;

  typedef struct packed {
    logic action;
    logic full;
    logic empty;
    logic match;
    logic srch_done;
    logic has_nodes;
    logic has_left;
    logic has_right;
    logic swap_needed;
    logic node_zero;
  } sts_t;
endpackage

[rtl/core/mhid_datapath.sv]
// Datapath for the binary min-heap: entry memory, count, pointers, compares.
// Depends on mhid_pkg.
module mhid_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mhid_pkg::ctl_t      ctl,
  input  mhid_pkg::in_word_t  in_word,
  output mhid_pkg::sts_t      sts,
  output mhid_pkg::out_word_t res
);
  mhid_pkg::val_t mem [mhid_pkg::HeapDepth];
  mhid_pkg::val_t rd_r;
  mhid_pkg::cnt_t cnt_r, cnt_nxt;
  mhid_pkg::cnt_t ptr_r, ptr_nxt;
  mhid_pkg::cnt_t node_r, node_nxt;
  mhid_pkg::cnt_t best_r, best_nxt;
  mhid_pkg::val_t bval_r, bval_nxt, nval_r, nval_nxt;
  mhid_pkg::val_t key_r;
  logic act_r;
  logic rd_en;
  mhid_pkg::cnt_t rd_addr, wr_addr;
  logic wr_en;
  mhid_pkg::val_t wr_data;
  mhid_pkg::cnt_t lft, rgt;
  mhid_pkg::cnt_t best_cand;
  mhid_pkg::out_word_t res_r;

  assign lft = mhid_pkg::cnt_t'({node_r, 1'b1});
  assign rgt = mhid_pkg::cnt_t'({node_r, 1'b0}) + mhid_pkg::cnt_t'(2);
  assign best_cand = ((rgt < cnt_r) && (rd_r < bval_r)) ? rgt : best_r;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = ptr_r;
    wr_en = 1'b0;
    wr_addr = ptr_r;
    wr_data = rd_r;
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    node_nxt = node_r;
    best_nxt = best_r;
    bval_nxt = bval_r;
    nval_nxt = nval_r;
    case (ctl.cmd)
      mhid_pkg::C_LOAD: begin
        ptr_nxt = '0;
      end
      mhid_pkg::C_APPEND: begin
        wr_en = 1'b1;
        wr_addr = cnt_r;
        wr_data = key_r;
        cnt_nxt = cnt_r + mhid_pkg::cnt_t'(1);
      end
      mhid_pkg::C_SRCH_RD: begin
        rd_en = 1'b1;
      end
      mhid_pkg::C_SRCH_STEP: begin
        ptr_nxt = ptr_r + mhid_pkg::cnt_t'(1);
      end
      mhid_pkg::C_DEL_A: begin
        rd_en = 1'b1;
        rd_addr = cnt_r - mhid_pkg::cnt_t'(1);
      end
      mhid_pkg::C_DEL_B: begin
        wr_en = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_r;
        cnt_nxt = cnt_r - mhid_pkg::cnt_t'(1);
      end
      mhid_pkg::C_NODE_INIT: begin
        node_nxt = (cnt_r >> 1) - mhid_pkg::cnt_t'(1);
      end
      mhid_pkg::C_RD_N: begin
        rd_en = 1'b1;
        rd_addr = node_r;
      end
      mhid_pkg::C_RD_L: begin
        rd_en = 1'b1;
        rd_addr = lft;
        nval_nxt = rd_r;
        bval_nxt = rd_r;
        best_nxt = node_r;
      end
      mhid_pkg::C_RD_R: begin
        rd_en = 1'b1;
        rd_addr = rgt;
        if (rd_r < bval_r) begin
          bval_nxt = rd_r;
          best_nxt = lft;
        end
      end
      mhid_pkg::C_SWAP_A: begin
        if (sts.has_right && rd_r < bval_r) begin
          bval_nxt = rd_r;
          best_nxt = rgt;
        end
      end
      mhid_pkg::C_SWAP_B: begin
        wr_en = 1'b1;
        wr_addr = best_r;
        wr_data = nval_r;
        node_nxt = best_r;
      end
      mhid_pkg::C_NODE_NEXT: begin
        node_nxt = ptr_r - mhid_pkg::cnt_t'(1);
      end
      mhid_pkg::C_RD_ROOT: begin
        rd_en = 1'b1;
        rd_addr = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[mhid_pkg::IdxBits-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr[mhid_pkg::IdxBits-1:0]];
    end
    if (ctl.cmd == mhid_pkg::C_SWAP_A && sts.swap_needed) begin
      mem[node_r[mhid_pkg::IdxBits-1:0]] <= bval_nxt;
    end
    if (ctl.cmd == mhid_pkg::C_LOAD) begin
      key_r <= in_word.item_value;
      act_r <= in_word.action;
    end
    if (ctl.cmd == mhid_pkg::C_NODE_INIT || ctl.cmd == mhid_pkg::C_NODE_NEXT) begin
      ptr_r <= node_nxt;
    end else begin
      ptr_r <= ptr_nxt;
    end
    node_r <= node_nxt;
    best_r <= best_nxt;
    bval_r <= bval_nxt;
    nval_r <= nval_nxt;
    if (ctl.cmd == mhid_pkg::C_STATUS) begin
      res_r.status <= ctl.status;
      res_r.entry_count <= 5'(cnt_r);
      res_r.min_value <= (cnt_r == '0) ? '0 : 32'(rd_r);
      res_r.heap_empty <= (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    sts.action = act_r;
    sts.full = (cnt_r >= mhid_pkg::cnt_t'(mhid_pkg::HeapDepth));
    sts.empty = (cnt_r == '0);
    sts.match = (rd_r == key_r);
    sts.srch_done = (ptr_r + mhid_pkg::cnt_t'(1) >= cnt_r);
    sts.has_nodes = (cnt_r >= mhid_pkg::cnt_t'(2));
    sts.has_left = (lft < cnt_r);
    sts.has_right = (rgt < cnt_r);
    sts.swap_needed = (best_cand != node_r);
    sts.node_zero = (ptr_r == '0);
  end

  assign res = res_r;
endmodule

[rtl/core/mhid_ctrl.sv]
// Controller for the binary min-heap: handshakes and the rebuild sequence.
// Depends on mhid_pkg.
module mhid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  mhid_pkg::sts_t sts,
  output mhid_pkg::ctl_t ctl
);
  mhid_pkg::state_t state_r, state_nxt;
  mhid_pkg::status_t stat_r, stat_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mhid_pkg::S_IDLE;
      stat_r <= mhid_pkg::ST_OK;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stat_r <= stat_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stat_nxt = stat_r;
    ov_nxt = ov_r;
    ctl.cmd = mhid_pkg::C_NONE;
    ctl.status = stat_r;
    in_ready = (state_r == mhid_pkg::S_IDLE);
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      mhid_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.cmd = mhid_pkg::C_LOAD;
          stat_nxt = mhid_pkg::ST_OK;
          state_nxt = mhid_pkg::S_INS;
        end
      end
      mhid_pkg::S_INS: begin
        if (sts.action == mhid_pkg::ActInsert) begin
          if (sts.full) begin
            stat_nxt = mhid_pkg::ST_FULL;
            state_nxt = mhid_pkg::S_ROOT;
          end else begin
            ctl.cmd = mhid_pkg::C_APPEND;
            state_nxt = mhid_pkg::S_NODE;
          end
        end else if (sts.empty) begin
          stat_nxt = mhid_pkg::ST_NOT_FOUND;
          state_nxt = mhid_pkg::S_ROOT;
        end else begin
          ctl.cmd = mhid_pkg::C_SRCH_RD;
          state_nxt = mhid_pkg::S_SRCH_CMP;
        end
      end
      mhid_pkg::S_SRCH_RD: begin
        ctl.cmd = mhid_pkg::C_SRCH_RD;
        state_nxt = mhid_pkg::S_SRCH_CMP;
      end
      mhid_pkg::S_SRCH_CMP: begin
        if (sts.match) begin
          state_nxt = mhid_pkg::S_DEL_A;
        end else if (sts.srch_done) begin
          stat_nxt = mhid_pkg::ST_NOT_FOUND;
          state_nxt = mhid_pkg::S_ROOT;
        end else begin
          ctl.cmd = mhid_pkg::C_SRCH_STEP;
          state_nxt = mhid_pkg::S_SRCH_RD;
        end
      end
      mhid_pkg::S_DEL_A: begin
        ctl.cmd = mhid_pkg::C_DEL_A;
        state_nxt = mhid_pkg::S_DEL_B;
      end
      mhid_pkg::S_DEL_B: begin
        ctl.cmd = mhid_pkg::C_DEL_B;
        state_nxt = mhid_pkg::S_NODE;
      end
      mhid_pkg::S_NODE: begin
        if (sts.has_nodes) begin
          ctl.cmd = mhid_pkg::C_NODE_INIT;
          state_nxt = mhid_pkg::S_RD_N;
        end else begin
          state_nxt = mhid_pkg::S_ROOT;
        end
      end
      mhid_pkg::S_RD_N: begin
        ctl.cmd = mhid_pkg::C_RD_N;
        state_nxt = mhid_pkg::S_RD_L;
      end
      mhid_pkg::S_RD_L: begin
        if (sts.has_left) begin
          ctl.cmd = mhid_pkg::C_RD_L;
          state_nxt = mhid_pkg::S_RD_R;
        end else if (sts.node_zero) begin
          state_nxt = mhid_pkg::S_ROOT;
        end else begin
          ctl.cmd = mhid_pkg::C_NODE_NEXT;
          state_nxt = mhid_pkg::S_RD_N;
        end
      end
      mhid_pkg::S_RD_R: begin
        ctl.cmd = mhid_pkg::C_RD_R;
        state_nxt = mhid_pkg::S_DECIDE;
      end
      mhid_pkg::S_DECIDE: begin
        ctl.cmd = mhid_pkg::C_SWAP_A;
        if (sts.swap_needed) begin
          state_nxt = mhid_pkg::S_SWAP_A;
        end else if (sts.node_zero) begin
          state_nxt = mhid_pkg::S_ROOT;
        end else begin
          state_nxt = mhid_pkg::S_SWAP_A;
        end
      end
      mhid_pkg::S_SWAP_A: begin
        if (sts.swap_needed) begin
          ctl.cmd = mhid_pkg::C_SWAP_B;
          state_nxt = mhid_pkg::S_RD_N;
        end else begin
          ctl.cmd = mhid_pkg::C_NODE_NEXT;
          state_nxt = mhid_pkg::S_RD_N;
        end
      end
      mhid_pkg::S_ROOT: begin
        ctl.cmd = mhid_pkg::C_RD_ROOT;
        state_nxt = mhid_pkg::S_OUT;
      end
      mhid_pkg::S_OUT: begin
        if (!ov_r || out_ready) begin
          ctl.cmd = mhid_pkg::C_STATUS;
          ov_nxt = 1'b1;
          state_nxt = mhid_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mhid_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = ov_r;
endmodule

[rtl/core/min_heap_insert_delete.sv]
// Channel     | Ports                             | Word
// input       | in_valid, in_ready, in_word       | action, item_value
// result      | out_valid, out_ready, out_word    | status, count, min, empty
// An insert appends the item and then rebuilds the heap; a delete searches the entries
// in order from entry 0, moves the last entry into the matching slot and then rebuilds.
// The rebuild sifts down each node that has children, from the last such node to the root.
// An insert into a full heap or a delete that finds no match goes straight to the result.
// Reset clears the count and control; entries are not cleared.
// A new word is taken while a result waits; the next result holds until that one goes.
// Depends on mhid_pkg, mhid_ctrl and mhid_datapath.
module min_heap_insert_delete (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mhid_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output mhid_pkg::out_word_t out_word
);
  mhid_pkg::ctl_t ctl;
  mhid_pkg::sts_t sts;

  mhid_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .ctl(ctl)
  );

  mhid_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .in_word(in_word), .sts(sts), .res(out_word)
  );
endmodule

[rtl/core/mhid_checker.sv]
// Port-level checker for the min-heap, bound to the top level.
// Depends on mhid_pkg and min_heap_insert_delete_macros.svh.
`include "min_heap_insert_delete_macros.svh"
module mhid_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mhid_pkg::in_word_t  in_word,
  input logic                out_valid,
  input logic                out_ready,
  input mhid_pkg::out_word_t out_word
);
  `MH_ASSERT_IMPL(a_empty, clk, rst_n, out_valid, (out_word.heap_empty == (out_word.entry_count == 5'd0)), "empty flag disagrees with count")
  `MH_ASSERT_IMPL(a_min0, clk, rst_n, out_valid && out_word.heap_empty, out_word.min_value == '0, "empty heap with nonzero min")
  `MH_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_word), "input word dropped")
  `MH_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word), "result dropped")
endmodule

bind min_heap_insert_delete mhid_checker u_chk (.*);
